// ===== hw/rtl/sspq_pkg.sv =====
`default_nettype none

package sspq_pkg;

   localparam int DEPTH_DEF = 16;

   localparam int REC_W  = 16;
   localparam int KEY_W  = 10;
   localparam int OCC_W  = 5;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      KEY_CLIENT_TYPE = 1'b0,
      KEY_ITEM_COUNT  = 1'b1
   } key_sel_type;

   // Field order matches the packed record: item count in the low bits.
   typedef struct packed {
      logic [2:0] payment_type;
      logic [2:0] client_type;
      logic [9:0] item_count;
   } rec_type;

   // Insert token handed from one cell to the next.
   typedef struct packed {
      logic    valid;
      logic    found;
      rec_type rec;
   } tok_type;

   function automatic logic [KEY_W-1:0] key_of(rec_type rec, key_sel_type sel);
      logic [KEY_W-1:0] k;
      unique case (sel)
         KEY_ITEM_COUNT:  k = rec.item_count;
         KEY_CLIENT_TYPE: k = {{(KEY_W-3){1'b0}}, rec.client_type};
         default:         k = '0;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sspq_cell.sv =====
`default_nettype none

module sspq_cell
   import sspq_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  key_sel_type key_sel,
   input  wire         occupied,
   input  wire         shift_en,
   input  rec_type     next_entry,
   input  tok_type     tok_in,
   output tok_type     tok_out,
   output rec_type     entry
);

   rec_type entry_ff, entry_in;
   tok_type tok_ff, tok_in_next;

   always_comb begin
      entry_in    = entry_ff;
      tok_in_next = '0;
      if (shift_en) begin
         entry_in = next_entry;
      end else if (tok_in.valid) begin
         if (!occupied) begin
            // First free cell: the token comes to rest here.
            entry_in = tok_in.rec;
         end else if (tok_in.found ||
                      (key_of(entry_ff, key_sel) > key_of(tok_in.rec, key_sel))) begin
            // Take the carried record and pass the displaced one along.
            entry_in    = tok_in.rec;
            tok_in_next = '{valid: 1'b1, found: 1'b1, rec: entry_ff};
         end else begin
            tok_in_next = tok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;
   assign entry   = entry_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/stable_sorted_priority_queue.sv =====
// Stable sorted priority queue of customer records.
// Input words arrive on req_*: req_tuser is the operation (insert or remove
// head), req_tdata the record to insert. Every accepted word yields exactly
// one result word on rsp_*: rsp_tuser is the status, rsp_tdata the removed
// record (zero for inserts and failures) and the occupancy after the operation.
// The sort key (client type or item count) is set through csr_write_en; the
// user must write it only while the block is idle, as the block does not
// enforce this. Held entries are not reordered by a key change.
// Records sit in a row of cells. A remove shifts every cell one place toward
// the head at once. An insert sends a token down the row, one cell per
// cycle; it displaces the first entry with a strictly greater key and ripples
// the displaced entries toward the tail.
// The result word is registered and appears in the cycle after acceptance.
// A remove or a failed insert does not hold off the next word; after an
// insert no further word is taken until its token has come to rest.
// When rsp_tready is low the result waits in its register, and no further
// word is taken until it leaves. Synchronous reset empties the store and
// selects the client type as key; no clearing pass is needed.
`default_nettype none

module stable_sorted_priority_queue
   import sspq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
)
(
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_write_en,
   input  wire         csr_write_data,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // item_count[9:0], client_type[12:10], payment_type[15:13]
   input  wire         req_tuser,   // op[0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // out_item_count[9:0], out_client_type[12:10],
                                    // out_payment_type[15:13], occupancy[20:16], zero[23:21]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int CW = $clog2(DEPTH + 1);

   key_sel_type key_sel_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] old_cnt_ff, old_cnt_in;
   logic [CW-1:0] wait_ff, wait_in;
   tok_type inj_ff, inj_in;
   logic rsp_valid_ff, rsp_valid_in;
   status_type status_ff, status_in;
   rec_type out_rec_ff, out_rec_in;
   logic [OCC_W-1:0] occ_ff, occ_in;

   tok_type tok [DEPTH+1];
   rec_type entries [DEPTH];
   logic [DEPTH-1:0] occupied;

   logic accept, is_full, is_empty, shift_en;
   op_type op;
   rec_type req_rec;
   logic [CW+OCC_W-1:0] occ_wide;

   assign op       = op_type'(req_tuser);
   assign req_rec  = rec_type'(req_tdata);
   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);

   assign req_tready = (wait_ff == '0) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign shift_en   = accept && (op == OP_REMOVE) && !is_empty;

   always_comb begin
      count_in     = count_ff;
      old_cnt_in   = old_cnt_ff;
      wait_in      = (wait_ff != '0) ? wait_ff - 1'b1 : wait_ff;
      inj_in       = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      out_rec_in   = out_rec_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = STATUS_DONE;
         out_rec_in   = '0;
         unique case (op)
            OP_INSERT: begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  count_in   = count_ff + 1'b1;
                  old_cnt_in = count_ff;
                  wait_in    = count_ff + 1'b1;
                  inj_in     = '{valid: 1'b1, found: 1'b0, rec: req_rec};
               end
            end
            OP_REMOVE: begin
               if (is_empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  count_in   = count_ff - 1'b1;
                  out_rec_in = entries[0];
               end
            end
            default: begin
               status_in = STATUS_DONE;
            end
         endcase
      end
      occ_wide = {{OCC_W{1'b0}}, count_in};
      occ_in   = accept ? occ_wide[OCC_W-1:0] : occ_ff;
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      out_rec_ff <= out_rec_in;
      occ_ff     <= occ_in;
      old_cnt_ff <= old_cnt_in;
      if (reset) begin
         key_sel_ff   <= KEY_CLIENT_TYPE;
         count_ff     <= '0;
         wait_ff      <= '0;
         inj_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            key_sel_ff <= key_sel_type'(csr_write_data);
         end
         count_ff     <= count_in;
         wait_ff      <= wait_in;
         inj_ff       <= inj_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign tok[0] = inj_ff;

   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      rec_type next_entry;
      if (gi == DEPTH - 1) begin : g_tail
         assign next_entry = entries[gi];
      end else begin : g_body
         assign next_entry = entries[gi+1];
      end
      assign occupied[gi] = (old_cnt_ff > CW'(gi));

      sspq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .key_sel    (key_sel_ff),
         .occupied   (occupied[gi]),
         .shift_en   (shift_en),
         .next_entry (next_entry),
         .tok_in     (tok[gi]),
         .tok_out    (tok[gi+1]),
         .entry      (entries[gi])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {3'b000, occ_ff, out_rec_ff};

`ifndef SYNTHESIS
   // A token always comes to rest before running off the end of the row.
   a_tok_absorbed: assert property (@(posedge clock) disable iff (reset)
      !tok[DEPTH].valid)
      else $error("insert token left the last cell");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("record count above depth");

   a_no_accept_mid_insert: assert property (@(posedge clock) disable iff (reset)
      inj_ff.valid |-> !req_tready)
      else $error("word accepted while an insert is moving down the row");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted word produced no result");
`endif

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
module tb;
   import sspq_pkg::*;

   localparam int DEPTH       = DEPTH_DEF;
   localparam int LIMIT       = 600000;
   localparam int PHASES      = 8;
   localparam int PHASE_WORDS = 190;
   localparam int HOLD_CYCLES = 300;

   // Predicts the sorted store and keeps the result words still to come.
   class customer_queue_model;
      typedef struct {
         status_type       status;
         rec_type          rec;
         logic [OCC_W-1:0] occ;
      } outcome_type;

      rec_type     held_records[$];
      outcome_type pending_outcomes[$];
      key_sel_type key_sel;
      int          depth;
      int          errors;

      function new(int d);
         depth   = d;
         key_sel = KEY_CLIENT_TYPE;
         errors  = 0;
      endfunction

      function logic [KEY_W-1:0] sort_key(rec_type r);
         if (key_sel == KEY_ITEM_COUNT) begin
            return r.item_count;
         end
         return {{(KEY_W-3){1'b0}}, r.client_type};
      endfunction

      function void note_request(op_type op, rec_type rec);
         outcome_type o;
         int          pos;
         o.status = STATUS_DONE;
         o.rec    = '0;
         if (op == OP_INSERT) begin
            if (held_records.size() >= depth) begin
               o.status = STATUS_FULL;
            end else begin
               // A new record goes just before the first entry with a greater key.
               pos = 0;
               while (pos < held_records.size() &&
                      sort_key(held_records[pos]) <= sort_key(rec)) begin
                  pos++;
               end
               held_records.insert(pos, rec);
            end
         end else if (held_records.size() == 0) begin
            o.status = STATUS_EMPTY;
         end else begin
            o.rec = held_records.pop_front();
         end
         o.occ = OCC_W'(held_records.size());
         pending_outcomes.push_back(o);
      endfunction

      task flag_mismatch(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      task check_response(logic [1:0] status, logic [23:0] data);
         outcome_type o;
         rec_type     got;
         if (pending_outcomes.size() == 0) begin
            flag_mismatch("result word arrived with nothing outstanding");
            return;
         end
         o   = pending_outcomes.pop_front();
         got = data[15:0];
         if (status != o.status) begin
            flag_mismatch($sformatf("status %0d, wanted %0d", status, o.status));
         end
         if (got.item_count != o.rec.item_count) begin
            flag_mismatch($sformatf("item count %0d, wanted %0d",
                                    got.item_count, o.rec.item_count));
         end
         if (got.client_type != o.rec.client_type) begin
            flag_mismatch($sformatf("client type %0d, wanted %0d",
                                    got.client_type, o.rec.client_type));
         end
         if (got.payment_type != o.rec.payment_type) begin
            flag_mismatch($sformatf("payment type %0d, wanted %0d",
                                    got.payment_type, o.rec.payment_type));
         end
         if (data[20:16] != o.occ) begin
            flag_mismatch($sformatf("occupancy %0d, wanted %0d", data[20:16], o.occ));
         end
         if (data[23:21] != 3'b000) begin
            flag_mismatch($sformatf("padding bits %0b not zero", data[23:21]));
         end
      endtask
   endclass

   logic        clock;
   logic        reset          = 1'b1;
   logic        csr_write_en   = 1'b0;
   logic        csr_write_data = 1'b0;
   logic        req_tvalid     = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata      = '0;
   logic        req_tuser      = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready     = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   customer_queue_model model = new(DEPTH);

   int cycle_count     = 0;
   bit hold_req        = 1'b0;
   int hold_left       = 0;
   int stall_mode      = 0;
   int stall_mode_left = 0;

   stable_sorted_priority_queue #(.DEPTH(DEPTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // The result is checked before the request is noted, so a word taken at the
   // same edge never matches its own prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         model.check_response(rsp_tuser, rsp_tdata);
      end
      if (!reset && req_tvalid && req_tready) begin
         model.note_request(op_type'(req_tuser), rec_type'(req_tdata));
      end
   end

   // Receiver: a long hold-off on request, otherwise one of four stall patterns,
   // redrawn at random.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(16, 96);
         end else begin
            stall_mode_left--;
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 7) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic send_word(op_type op, rec_type rec);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= rec;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic insert_rec(int ic, int ct, int pt);
      rec_type r;
      r.item_count   = 10'(ic);
      r.client_type  = 3'(ct);
      r.payment_type = 3'(pt);
      send_word(OP_INSERT, r);
   endtask

   task automatic idle_sender(int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      idle_sender(1);
      while (model.pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // An insert may still be walking the row after its result has left, so
   // the key changes only after a full walk has had time to finish.
   task automatic write_sort_key(key_sel_type k);
      wait_drained();
      repeat (DEPTH + 4) @(posedge clock);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= k;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      model.key_sel = k;
   endtask

   function automatic rec_type random_record();
      rec_type r;
      int      pick;
      pick = $urandom_range(0, 7);
      if (pick < 2) begin
         r.item_count = 10'($urandom_range(0, 3));
      end else if (pick == 2) begin
         r.item_count = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
      end else begin
         r.item_count = 10'($urandom_range(0, 1023));
      end
      r.client_type  = 3'($urandom_range(0, 7));
      r.payment_type = 3'($urandom_range(0, 7));
      return r;
   endfunction

   initial begin
      int     sent;
      int     burst;
      int     insert_bias;
      op_type op;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset key: empty remove, ties, extremes, full.
      send_word(OP_REMOVE, '0);
      insert_rec(0, 0, 0);
      insert_rec(1023, 7, 7);
      insert_rec(5, 3, 1);
      insert_rec(6, 3, 2);
      insert_rec(7, 3, 3);
      insert_rec(1023, 0, 7);
      insert_rec(0, 7, 0);
      insert_rec(512, 4, 5);
      insert_rec(9, 3, 4);
      insert_rec(10, 1, 6);
      insert_rec(11, 7, 1);
      insert_rec(12, 0, 2);
      insert_rec(13, 5, 3);
      insert_rec(14, 2, 4);
      insert_rec(15, 6, 5);
      insert_rec(16, 3, 6);
      insert_rec(100, 2, 2);
      send_word(OP_REMOVE, '0);
      send_word(OP_REMOVE, '0);
      send_word(OP_REMOVE, '0);

      // Switch the key with entries held; they stay in their old order.
      write_sort_key(KEY_ITEM_COUNT);
      insert_rec(0, 7, 7);
      insert_rec(1023, 0, 0);
      insert_rec(500, 1, 1);

      for (int phase = 0; phase < PHASES; phase++) begin
         write_sort_key(key_sel_type'(phase[0]));
         case (phase % 4)
            0: insert_bias = 70;
            1: insert_bias = 50;
            2: insert_bias = 85;
            default: insert_bias = 30;
         endcase
         sent = 0;
         while (sent < PHASE_WORDS) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < PHASE_WORDS; i++) begin
               if (phase == 2 && sent == PHASE_WORDS / 2) begin
                  hold_req = 1'b1;
               end
               if (phase == 5 && sent == PHASE_WORDS / 2) begin
                  wait_drained();
               end
               op = ($urandom_range(0, 99) < insert_bias) ? OP_INSERT : OP_REMOVE;
               send_word(op, random_record());
               sent++;
            end
            if (phase != 3 && $urandom_range(0, 3) != 0) begin
               idle_sender($urandom_range(1, 6));
            end
         end
      end

      wait_drained();
      repeat (DEPTH + 20) @(posedge clock);
      if (model.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
